FILE: design/sidm_pkg.sv
// ----------------------------------------------------------------------------
// sidm_pkg
// Shared types, codes and constants of the sorted id map lookup block.
// ----------------------------------------------------------------------------
package sidm_pkg;

   localparam int TABLE_DEPTH_DEF = 256;

   localparam int KeyW   = 32;
   localparam int FieldW = 31;
   localparam int TotalW = 9;
   localparam int CmdW   = 2;
   localparam int StatW  = 2;

   localparam int ReqDataW = 2 * KeyW;
   localparam int RspDataW = FieldW + TotalW;

   // Command codes carried on req_tuser.
   localparam logic [CmdW-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CmdW-1:0] CMD_LOAD   = 2'd1;
   localparam logic [CmdW-1:0] CMD_SEARCH = 2'd2;

   // Status codes carried on rsp_tuser.
   localparam logic [StatW-1:0] STAT_OK        = 2'd0;
   localparam logic [StatW-1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [StatW-1:0] STAT_FULL      = 2'd2;
   localparam logic [StatW-1:0] STAT_INVALID   = 2'd3;

   typedef struct packed {
      logic [FieldW-1:0] id;
      logic [FieldW-1:0] content;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              latch_req;
      logic              clear_cnt;
      logic              ins_rd;
      logic              ins_shift;
      logic              ins_place;
      logic              srch_init;
      logic              srch_rd;
      logic              srch_lo;
      logic              srch_hi;
      logic              load_rsp;
      logic              rsp_found;
      logic [StatW-1:0]  rsp_status;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [CmdW-1:0]   command;
      logic              key_neg;
      logic              val_neg;
      logic              full;
      logic              pos_zero;
      logic              range_empty;
      logic              probe_lt;
      logic              probe_eq;
      logic              probe_gt;
   } dp_stat_type;

endpackage

FILE: design/sidm_dp.sv
// ----------------------------------------------------------------------------
// sidm_dp
// Datapath: sorted entry memory, entry count, insertion pointer, search
// bounds and the result register.
// ----------------------------------------------------------------------------
module sidm_dp #(
   parameter int TABLE_DEPTH = sidm_pkg::TABLE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [sidm_pkg::CmdW-1:0]       req_command,
   input  logic [sidm_pkg::KeyW-1:0]       req_key,
   input  logic [sidm_pkg::KeyW-1:0]       req_value,
   input  sidm_pkg::dp_cmd_type            cmd,
   output sidm_pkg::dp_stat_type           stat,
   output logic [sidm_pkg::StatW-1:0]      rsp_status,
   output logic [sidm_pkg::FieldW-1:0]     rsp_found,
   output logic [sidm_pkg::TotalW-1:0]     rsp_total
);
   import sidm_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int XW = (CW > TotalW) ? CW : TotalW;

   entry_type         mem [TABLE_DEPTH];
   entry_type         rdata_ff;

   logic [CmdW-1:0]   command_ff;
   logic [KeyW-1:0]   key_ff;
   logic [KeyW-1:0]   value_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     pos_ff, pos_in;
   logic [CW-1:0]     lo_ff, lo_in;
   logic [CW-1:0]     hi_ff, hi_in;
   logic [CW-1:0]     mid_ff;
   logic [CW-1:0]     pos_dec;
   logic [CW:0]       mid_sum;
   logic [CW-1:0]     mid;
   logic [XW-1:0]     count_ext;
   logic [StatW-1:0]  status_ff;
   logic [FieldW-1:0] found_ff;
   logic [TotalW-1:0] total_ff;

   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   entry_type         mem_wdata;
   logic              mem_re;
   logic [AW-1:0]     mem_raddr;

   assign pos_dec = pos_ff - CW'(1);
   // Midpoint of the inclusive range [lo, hi-1]; only used while lo < hi.
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff} - (CW + 1)'(1);
   assign mid     = mid_sum[CW:1];

   always_comb begin
      mem_we    = cmd.ins_shift | cmd.ins_place;
      mem_waddr = pos_ff[AW-1:0];
      mem_wdata = cmd.ins_shift ? rdata_ff
                : entry_type'{id: key_ff[FieldW-1:0], content: value_ff[FieldW-1:0]};
      mem_re    = cmd.ins_rd | cmd.srch_rd;
      mem_raddr = cmd.srch_rd ? mid[AW-1:0] : pos_dec[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      if (cmd.clear_cnt) begin
         count_in = '0;
      end else if (cmd.ins_place) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.latch_req) begin
         pos_in = count_ff;
      end else if (cmd.ins_shift) begin
         pos_in = pos_dec;
      end
      if (cmd.srch_init) begin
         lo_in = '0;
         hi_in = count_ff;
      end else if (cmd.srch_lo) begin
         lo_in = mid_ff + CW'(1);
      end else if (cmd.srch_hi) begin
         hi_in = mid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      if (cmd.srch_rd) begin
         mid_ff <= mid;
      end
      if (cmd.latch_req) begin
         command_ff <= req_command;
         key_ff     <= req_key;
         value_ff   <= req_value;
      end
   end

   assign count_ext = XW'(count_ff);

   // Result register; the read data stays put until the result is loaded.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         status_ff <= cmd.rsp_status;
         found_ff  <= cmd.rsp_found ? rdata_ff.content : '0;
         total_ff  <= count_ext[TotalW-1:0];
      end
   end

   always_comb begin
      stat.command     = command_ff;
      stat.key_neg     = key_ff[KeyW-1];
      stat.val_neg     = value_ff[KeyW-1];
      stat.full        = (count_ff >= CW'(TABLE_DEPTH));
      stat.pos_zero    = (pos_ff == '0);
      stat.range_empty = (lo_ff >= hi_ff);
      stat.probe_lt    = (rdata_ff.id < key_ff[FieldW-1:0]);
      stat.probe_eq    = (rdata_ff.id == key_ff[FieldW-1:0]);
      stat.probe_gt    = (rdata_ff.id > key_ff[FieldW-1:0]);
   end

   assign rsp_status = status_ff;
   assign rsp_found  = found_ff;
   assign rsp_total  = total_ff;

endmodule

FILE: design/sidm_ctrl.sv
// ----------------------------------------------------------------------------
// sidm_ctrl
// Controller: sequences clear, insertion and binary search steps and owns
// the handshakes of both channels.
// ----------------------------------------------------------------------------
module sidm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  sidm_pkg::dp_stat_type  stat,
   output sidm_pkg::dp_cmd_type   cmd
);
   import sidm_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DECODE   = 3'd1;
   localparam logic [2:0] ST_INS_RD   = 3'd2;
   localparam logic [2:0] ST_INS_CMP  = 3'd3;
   localparam logic [2:0] ST_SRCH_RD  = 3'd4;
   localparam logic [2:0] ST_SRCH_CMP = 3'd5;
   localparam logic [2:0] ST_DONE     = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [StatW-1:0] status_ff, status_in;
   logic             found_ff, found_in;
   logic             valid_ff, valid_in;
   logic             slot_free;

   assign slot_free  = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in       = state_ff;
      status_in      = status_ff;
      found_in       = found_ff;
      cmd            = '0;
      cmd.rsp_status = status_ff;
      cmd.rsp_found  = found_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            status_in = STAT_OK;
            found_in  = 1'b0;
            state_in  = ST_DONE;
            case (stat.command)
               CMD_CLEAR: begin
                  cmd.clear_cnt = 1'b1;
               end
               CMD_LOAD: begin
                  // The invalid check takes priority over the full check.
                  if (stat.key_neg || stat.val_neg) begin
                     status_in = STAT_INVALID;
                  end else if (stat.full) begin
                     status_in = STAT_FULL;
                  end else begin
                     state_in = ST_INS_RD;
                  end
               end
               CMD_SEARCH: begin
                  if (stat.key_neg) begin
                     status_in = STAT_NOT_FOUND;
                  end else begin
                     cmd.srch_init = 1'b1;
                     state_in      = ST_SRCH_RD;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_INS_RD: begin
            if (stat.pos_zero) begin
               cmd.ins_place = 1'b1;
               state_in      = ST_DONE;
            end else begin
               cmd.ins_rd = 1'b1;
               state_in   = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            // Larger entries move up one place; equal ids stay below the new one.
            if (stat.probe_gt) begin
               cmd.ins_shift = 1'b1;
               state_in      = ST_INS_RD;
            end else begin
               cmd.ins_place = 1'b1;
               state_in      = ST_DONE;
            end
         end
         ST_SRCH_RD: begin
            if (stat.range_empty) begin
               status_in = STAT_NOT_FOUND;
               state_in  = ST_DONE;
            end else begin
               cmd.srch_rd = 1'b1;
               state_in    = ST_SRCH_CMP;
            end
         end
         ST_SRCH_CMP: begin
            if (stat.probe_eq) begin
               found_in = 1'b1;
               state_in = ST_DONE;
            end else if (stat.probe_lt) begin
               cmd.srch_lo = 1'b1;
               state_in    = ST_SRCH_RD;
            end else begin
               cmd.srch_hi = 1'b1;
               state_in    = ST_SRCH_RD;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.load_rsp) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      found_ff  <= found_in;
   end

endmodule

FILE: design/sorted_id_map_lookup.sv
// ----------------------------------------------------------------------------
// sorted_id_map_lookup
// Table of id/content pairs held in ascending id order with clear, sorted
// insertion and binary search commands.
// ----------------------------------------------------------------------------
// The request channel carries one command per transaction: clear, load of
// an id/content pair, or search by id. Every request gives exactly one
// response transaction with a status, the found content and the number of
// entries held afterwards.
// Items are handled one at a time. The entry memory has one write and one
// registered read port, and each insertion shift or search probe is a read
// step followed by a compare step. From acceptance to a valid response:
//   clear, rejected load, negative search id, reserved command: decode,
//   then the final step; load: decode, a read and compare per entry moved
//   up and for the entry below it (none when the pair lands lowest), then
//   the final step; search: decode and a read and compare per probe, with
//   log2(depth) + 1 probes at most, plus a range check for a missing id.
// A new request is taken in the cycle after the previous response is loaded
// into the output register, so no request is taken while one is in work.
// If the receiver stalls, the finished result waits in its final step until
// the register frees up. Synchronous reset empties the table (the count goes
// to zero) and drops any pending response; the memory needs no clearing.
// ----------------------------------------------------------------------------
module sorted_id_map_lookup #(
   parameter int TABLE_DEPTH = sidm_pkg::TABLE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // key_id [31:0], value [63:32]
   input  logic [sidm_pkg::ReqDataW-1:0]   req_tdata,
   // command [1:0]
   input  logic [sidm_pkg::CmdW-1:0]       req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // found_content [30:0], entry_total [39:31]
   output logic [sidm_pkg::RspDataW-1:0]   rsp_tdata,
   // status [1:0]
   output logic [sidm_pkg::StatW-1:0]      rsp_tuser
);
   import sidm_pkg::*;

   dp_cmd_type        cmd;
   dp_stat_type       stat;
   logic [FieldW-1:0] rsp_found;
   logic [TotalW-1:0] rsp_total;

   sidm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sidm_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_command (req_tuser),
      .req_key     (req_tdata[KeyW-1:0]),
      .req_value   (req_tdata[2*KeyW-1:KeyW]),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_status  (rsp_tuser),
      .rsp_found   (rsp_found),
      .rsp_total   (rsp_total)
   );

   assign rsp_tdata = {rsp_total, rsp_found};

endmodule

FILE: design/sidm_checker.sv
// ----------------------------------------------------------------------------
// sidm_checker
// Port-level checks of the sorted id map lookup block.
// ----------------------------------------------------------------------------
module sidm_checker #(
   parameter int TABLE_DEPTH = sidm_pkg::TABLE_DEPTH_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [sidm_pkg::RspDataW-1:0]   rsp_tdata,
   input logic [sidm_pkg::StatW-1:0]      rsp_tuser
);
   import sidm_pkg::*;

   localparam logic [TotalW-1:0] FullTotal = TotalW'(TABLE_DEPTH);

   // A response never appears in the cycle right after reset.
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // Requests are taken one at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted in back-to-back cycles");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // Content is only reported on a found search.
   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STAT_OK |-> rsp_tdata[FieldW-1:0] == '0)
      else $error("content reported without a match");

   // A full table reports a count equal to the depth.
   a_full_total: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STAT_FULL |->
         rsp_tdata[RspDataW-1:FieldW] == FullTotal)
      else $error("table full reported with a wrong entry count");

endmodule

bind sorted_id_map_lookup sidm_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_sidm_checker (.*);
